// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants and types of the circular deque
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    localparam logic [1:0] REQ_PUSH_RIGHT = 2'd0;
    localparam logic [1:0] REQ_PUSH_LEFT  = 2'd1;
    localparam logic [1:0] REQ_POP_RIGHT  = 2'd2;
    localparam logic [1:0] REQ_POP_LEFT   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       pop_ok;
    } t_req_res;

endpackage

`default_nettype wire

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// double-ended queue of signed 32-bit words held in a circular ram
// ----------------------------------------------------------------------------
// requests come in on the slave stream: tuser carries the request kind
// (push right, push left, pop right, pop left), tdata the word to push.
// every request yields exactly one result word on the master stream:
// tuser carries the status (ok, full, empty), tdata the popped word or zero.
// pointers are updated in the cycle a request is accepted and the ram is
// written or read in that same cycle; the ram read data is registered
// beside the read stage and passes on into the result register. the single
// ram port limits the rate to one request per cycle while results are taken.
// a stalled receiver holds the result register; one further request may
// sit in the read stage, after which tready drops until the result is taken.
// after reset the deque is empty, both pointers at entry zero, no result
// pending; the ram needs no clearing pass since entries are read only after
// they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output      logic        o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // push_value
    input  wire logic [1:0]  i_s_tuser,   // req_type
    output      logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output      logic [31:0] o_m_tdata,   // pop_value
    output      logic [1:0]  o_m_tuser    // status
);

    cdq_pkg::t_mem_cmd          cmd;
    cdq_pkg::t_req_res          res;
    logic [cdq_pkg::DATA_W-1:0] rdata;
    logic                       accept;
    logic                       s1_adv;

    logic                       r_s1_valid;
    cdq_pkg::t_req_res          r_s1_res;
    logic                       r_out_valid;
    logic [cdq_pkg::DATA_W-1:0] r_out_data;
    logic [1:0]                 r_out_status;

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_req   (i_s_tuser),
        .i_value (i_s_tdata),
        .o_cmd   (cmd),
        .o_res   (res)
    );

    cdq_ram #(
        .DATA_W(cdq_pkg::DATA_W),
        .ADDR_W(cdq_pkg::ADDR_W),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (cmd.we),
        .i_re   (cmd.re),
        .i_addr (cmd.addr),
        .i_wdata(cmd.wdata),
        .o_rdata(rdata)
    );

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_res <= res;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_status <= r_s1_res.status;
            r_out_data   <= r_s1_res.pop_ok ? rdata : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;

endmodule

`default_nettype wire

// ===== src/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// single-port synchronous ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7,
    parameter int DEPTH  = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// end pointers and empty flag, issues at most one ram access per accepted request
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [1:0]                    i_req,
    input  wire logic [cdq_pkg::DATA_W-1:0]    i_value,
    output      cdq_pkg::t_mem_cmd             o_cmd,
    output      cdq_pkg::t_req_res             o_res
);

    localparam logic [cdq_pkg::ADDR_W-1:0] LAST = cdq_pkg::ADDR_W'(cdq_pkg::DEPTH - 1);

    logic [cdq_pkg::ADDR_W-1:0] r_left, n_left;
    logic [cdq_pkg::ADDR_W-1:0] r_right, n_right;
    logic                       r_empty, n_empty;
    logic [cdq_pkg::ADDR_W-1:0] right_inc, right_dec, left_inc, left_dec;
    logic                       full;

    always_comb begin
        right_inc = (r_right == LAST) ? '0 : r_right + 1'b1;
        right_dec = (r_right == '0) ? LAST : r_right - 1'b1;
        left_inc  = (r_left == LAST) ? '0 : r_left + 1'b1;
        left_dec  = (r_left == '0) ? LAST : r_left - 1'b1;
        full      = !r_empty && (right_inc == r_left);
    end

    always_comb begin
        n_left      = r_left;
        n_right     = r_right;
        n_empty     = r_empty;
        o_cmd.we    = 1'b0;
        o_cmd.re    = 1'b0;
        o_cmd.addr  = '0;
        o_cmd.wdata = i_value;
        o_res.status = cdq_pkg::ST_OK;
        o_res.pop_ok = 1'b0;
        case (i_req)
            cdq_pkg::REQ_PUSH_RIGHT, cdq_pkg::REQ_PUSH_LEFT: begin
                if (full) begin
                    o_res.status = cdq_pkg::ST_FULL;
                end else begin
                    o_cmd.we = i_accept;
                    if (r_empty) begin
                        n_left     = '0;
                        n_right    = '0;
                        n_empty    = 1'b0;
                        o_cmd.addr = '0;
                    end else if (i_req == cdq_pkg::REQ_PUSH_RIGHT) begin
                        n_right    = right_inc;
                        o_cmd.addr = right_inc;
                    end else begin
                        n_left     = left_dec;
                        o_cmd.addr = left_dec;
                    end
                end
            end
            cdq_pkg::REQ_POP_RIGHT, cdq_pkg::REQ_POP_LEFT: begin
                if (r_empty) begin
                    o_res.status = cdq_pkg::ST_EMPTY;
                end else begin
                    o_cmd.re     = i_accept;
                    o_res.pop_ok = 1'b1;
                    o_cmd.addr   = (i_req == cdq_pkg::REQ_POP_RIGHT) ? r_right : r_left;
                    if (r_left == r_right) begin
                        n_empty = 1'b1;
                        n_left  = '0;
                        n_right = '0;
                    end else if (i_req == cdq_pkg::REQ_POP_RIGHT) begin
                        n_right = right_dec;
                    end else begin
                        n_left = left_inc;
                    end
                end
            end
            default: begin
                o_res.status = cdq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_empty <= 1'b1;
        end else if (i_accept) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_empty <= n_empty;
        end
    end

endmodule

`default_nettype wire
